// File: hw/rtl/pcc_pkg.sv
package pcc_pkg;

  // Default coordinate width of the vertex ports
  localparam int unsigned COORD_BITS = 32;

  // Number of turns that one vertex can check: the regular turn and the two closing turns
  localparam int unsigned TURNS = 3;

  // Orientation codes: undecided, positive, negative (minus one in two bits)
  typedef enum logic [1:0] {
    ORIENT_NONE = 2'd0,
    ORIENT_POS  = 2'd1,
    ORIENT_NEG  = 2'd3
  } orient_t;

endpackage

// File: hw/rtl/polygon_convexity_check.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_vertex_x, in_vertex_y, in_last_vertex
// out_     output     out_valid/out_stall out_is_convex
//
// One vertex per cycle while in_stall is low. out_valid is registered after the last vertex leaves stage 2.
// The rate is set by the six-multiplier cross product stage, which is fully pipelined.
// rst_n is synchronous and active low; it clears the pipeline valids and polygon state.
// The output register holds a result while out_stall is high. Input keeps flowing
// until a second result reaches the end of the pipeline; then in_stall rises.
module polygon_convexity_check #(
  parameter int unsigned COORD_BITS = pcc_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_vertex_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_y,
  input  logic                         in_last_vertex,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_is_convex
);

  localparam int unsigned EDGE_BITS = COORD_BITS + 1;
  localparam int unsigned PROD_BITS = 2 * EDGE_BITS;
  localparam int unsigned TURNS     = pcc_pkg::TURNS;

  // Polygon geometry state, tracked at the input
  logic [1:0]                  vs_r;
  logic signed [COORD_BITS-1:0] first_pt_x_r, first_pt_y_r;
  logic signed [COORD_BITS-1:0] prev_pt_x_r, prev_pt_y_r;
  logic signed [EDGE_BITS-1:0]  prev_edge_x_r, prev_edge_y_r;
  logic signed [EDGE_BITS-1:0]  first_edge_x_r, first_edge_y_r;

  // Stage 1: turn operands
  logic                        s1_valid_r, s1_last_r;
  logic [TURNS-1:0]            s1_en_r;
  logic signed [EDGE_BITS-1:0] s1_ax_r [TURNS];
  logic signed [EDGE_BITS-1:0] s1_ay_r [TURNS];
  logic signed [EDGE_BITS-1:0] s1_bx_r [TURNS];
  logic signed [EDGE_BITS-1:0] s1_by_r [TURNS];

  // Stage 2: cross product halves
  logic                        s2_valid_r, s2_last_r;
  logic [TURNS-1:0]            s2_en_r;
  logic signed [PROD_BITS-1:0] s2_pl_r [TURNS];
  logic signed [PROD_BITS-1:0] s2_pr_r [TURNS];

  // Stage 3: orientation and result
  pcc_pkg::orient_t orient_r, orient_nxt;
  logic             viol_r, viol_nxt;
  logic             out_valid_r, out_is_convex_r;

  logic in_fire, hold;
  logic signed [EDGE_BITS-1:0] e_x, e_y, ec_x, ec_y;
  logic signed [EDGE_BITS-1:0] pe_x, pe_y, fe_x, fe_y;
  logic signed [EDGE_BITS-1:0] ax [TURNS];
  logic signed [EDGE_BITS-1:0] ay [TURNS];
  logic signed [EDGE_BITS-1:0] bx [TURNS];
  logic signed [EDGE_BITS-1:0] by [TURNS];
  logic [TURNS-1:0]            en;

  // Freeze the whole pipeline only when a result is due and the output is still full
  assign hold     = s2_valid_r && s2_last_r && out_valid_r && out_stall;
  assign in_stall = hold;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid     = out_valid_r;
  assign out_is_convex = out_is_convex_r;

  always_comb begin
    e_x  = EDGE_BITS'(in_vertex_x) - EDGE_BITS'(prev_pt_x_r);
    e_y  = EDGE_BITS'(in_vertex_y) - EDGE_BITS'(prev_pt_y_r);
    ec_x = EDGE_BITS'(first_pt_x_r) - EDGE_BITS'(in_vertex_x);
    ec_y = EDGE_BITS'(first_pt_y_r) - EDGE_BITS'(in_vertex_y);
    // Edges as they stand after this vertex
    pe_x = (vs_r != 2'd0) ? e_x : prev_edge_x_r;
    pe_y = (vs_r != 2'd0) ? e_y : prev_edge_y_r;
    fe_x = (vs_r == 2'd1) ? e_x : first_edge_x_r;
    fe_y = (vs_r == 2'd1) ? e_y : first_edge_y_r;

    ax[0] = prev_edge_x_r; ay[0] = prev_edge_y_r; bx[0] = e_x;  by[0] = e_y;
    ax[1] = pe_x;          ay[1] = pe_y;          bx[1] = ec_x; by[1] = ec_y;
    ax[2] = ec_x;          ay[2] = ec_y;          bx[2] = fe_x; by[2] = fe_y;

    en[0] = (vs_r == 2'd2);
    en[1] = in_last_vertex && (vs_r != 2'd0);
    en[2] = in_last_vertex && (vs_r != 2'd0);
  end

  // Geometry state control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 2'd0;
    end else if (in_fire) begin
      if (in_last_vertex) begin
        vs_r <= 2'd0;
      end else if (vs_r != 2'd2) begin
        vs_r <= vs_r + 2'd1;
      end
    end
  end

  // Geometry payload; vs_r gates every use, so no reset
  always_ff @(posedge clk) begin
    if (in_fire && !in_last_vertex) begin
      if (vs_r == 2'd0) begin
        first_pt_x_r <= in_vertex_x;
        first_pt_y_r <= in_vertex_y;
      end else begin
        prev_edge_x_r <= e_x;
        prev_edge_y_r <= e_y;
      end
      if (vs_r == 2'd1) begin
        first_edge_x_r <= e_x;
        first_edge_y_r <= e_y;
      end
      prev_pt_x_r <= in_vertex_x;
      prev_pt_y_r <= in_vertex_y;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (!hold) begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_last_r <= in_last_vertex;
      s1_en_r   <= en;
      for (int i = 0; i < TURNS; i++) begin
        s1_ax_r[i] <= ax[i];
        s1_ay_r[i] <= ay[i];
        s1_bx_r[i] <= bx[i];
        s1_by_r[i] <= by[i];
      end
      s2_last_r <= s1_last_r;
      s2_en_r   <= s1_en_r;
      for (int i = 0; i < TURNS; i++) begin
        s2_pl_r[i] <= s1_bx_r[i] * s1_ay_r[i];
        s2_pr_r[i] <= s1_ax_r[i] * s1_by_r[i];
      end
    end
  end

  // Fold the turns of one vertex into the orientation, in order
  always_comb begin
    pcc_pkg::orient_t code;
    orient_nxt = orient_r;
    viol_nxt   = viol_r;
    for (int i = 0; i < TURNS; i++) begin
      if (s2_pl_r[i] > s2_pr_r[i]) begin
        code = pcc_pkg::ORIENT_POS;
      end else if (s2_pl_r[i] < s2_pr_r[i]) begin
        code = pcc_pkg::ORIENT_NEG;
      end else begin
        code = pcc_pkg::ORIENT_NONE;
      end
      if (s2_en_r[i] && code != pcc_pkg::ORIENT_NONE) begin
        if (orient_nxt == pcc_pkg::ORIENT_NONE) begin
          orient_nxt = code;
        end else if (orient_nxt != code) begin
          viol_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r    <= pcc_pkg::ORIENT_NONE;
      viol_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (!hold && s2_valid_r) begin
        if (s2_last_r) begin
          orient_r    <= pcc_pkg::ORIENT_NONE;
          viol_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end else begin
          orient_r <= orient_nxt;
          viol_r   <= viol_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && s2_valid_r && s2_last_r) begin
      out_is_convex_r <= !viol_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && s2_last_r))
    else $error("input stalled without a blocked result");

  a_viol_needs_orient: assert property (@(posedge clk) disable iff (!rst_n)
    viol_r |-> (orient_r != pcc_pkg::ORIENT_NONE))
    else $error("violation flagged with undecided orientation");

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_vertex) |=> (vs_r == 2'd0))
    else $error("vertex count not cleared after last vertex");
`endif

endmodule
